@@ src/mrp_pkg.sv @@
`default_nettype none
package mrp_pkg;

   // Bytes in one user-data block; the block also ends early on the last flag
   localparam int BlockBytes = 80;

   localparam logic [7:0] FillerByte  = 8'h2F;
   localparam logic [7:0] VifTime     = 8'h6D;
   localparam logic [7:0] VifeNeg     = 8'h3C;
   localparam logic [7:0] VifeReact   = 8'h73;
   localparam logic [7:0] DifLong     = 8'h84;
   localparam logic [7:0] DifeTariff  = 8'h10;
   localparam logic [7:0] VifExtFb    = 8'hFB;
   localparam logic [7:0] VifPower    = 8'h2B;
   localparam logic [7:0] VifPowerExt = 8'hAB;
   localparam logic [7:0] VifEnergyEx = 8'h83;
   localparam logic [7:0] VifeReactP  = 8'h14;
   localparam logic [7:0] DifInt32    = 8'h04;
   localparam logic [7:0] VifEnergy   = 8'h03;
   localparam logic [7:0] VifePrepay  = 8'h04;
   localparam logic [7:0] DifStopA    = 8'h0F;
   localparam logic [7:0] DifStopB    = 8'h1F;
   localparam logic [3:0] DifVarNib   = 4'hD;

   localparam logic [3:0] QtyTime      = 4'd0;
   localparam logic [3:0] QtyEnergyAp  = 4'd1;
   localparam logic [3:0] QtyEnergyAm  = 4'd2;
   localparam logic [3:0] QtyEnergyRp  = 4'd3;
   localparam logic [3:0] QtyEnergyRm  = 4'd4;
   localparam logic [3:0] QtyPowerP    = 4'd5;
   localparam logic [3:0] QtyPowerPm   = 4'd6;
   localparam logic [3:0] QtyPowerQ    = 4'd7;
   localparam logic [3:0] QtyPowerQm   = 4'd8;
   localparam logic [3:0] QtyPrepay    = 4'd9;

   localparam logic [11:0] YearBase = 12'd2000;

   typedef enum logic [2:0] {
      PH_SKIP = 3'd0,
      PH_DIF  = 3'd1,
      PH_DIFE = 3'd2,
      PH_VIF  = 3'd3,
      PH_VIFE = 3'd4,
      PH_DATA = 3'd5,
      PH_HALT = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  quantity;
      logic [31:0] value;
      logic [5:0]  ts_second;
      logic [5:0]  ts_minute;
      logic [4:0]  ts_hour;
      logic [4:0]  ts_day;
      logic [3:0]  ts_month;
      logic [11:0] ts_year;
      logic        ts_dst;
   } rsp_type;

   // Completed record handed from the parser to the decoder
   typedef struct packed {
      logic        done;
      logic [7:0]  dif;
      logic [7:0]  dif_ext;
      logic [7:0]  vif;
      logic [7:0]  vif_ext;
      logic [39:0] rec_bytes;
   } record_type;

   // Data length from the low nibble of the DIF
   function automatic logic [3:0] dif_payload_len(input logic [3:0] nib);
      logic [3:0] len;
      case (nib)
         4'h0: len = 4'd0;
         4'h1: len = 4'd1;
         4'h2: len = 4'd2;
         4'h3: len = 4'd3;
         4'h4: len = 4'd4;
         4'h5: len = 4'd4;
         4'h6: len = 4'd6;
         4'h7: len = 4'd8;
         4'h8: len = 4'd0;
         4'h9: len = 4'd1;
         4'hA: len = 4'd2;
         4'hB: len = 4'd3;
         4'hC: len = 4'd4;
         4'hD: len = 4'd0;
         4'hE: len = 4'd6;
         default: len = 4'd8;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

@@ src/mrp_parser.sv @@
`default_nettype none
module mrp_parser
   import mrp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire req_type    req,
   output record_type      record
);

   localparam logic [7:0] LastPos = 8'(BlockBytes);

   phase_type   phase_ff, phase_in, phase_nx;
   logic [6:0]  pos_ff, pos_in;
   logic [7:0]  dif_ff, dif_in, dif_nx;
   logic [7:0]  dife_ff, dife_in, dife_nx;
   logic [7:0]  vif_ff, vif_in, vif_nx;
   logic [7:0]  vife_ff, vife_in, vife_nx;
   logic [3:0]  left_ff, left_in, left_nx;
   logic [39:0] bytes_ff, bytes_in, bytes_nx;
   logic [3:0]  len, idx;
   logic        done, block_end;
   logic [7:0]  b;

   assign b = req.data_byte;

   // Block ends on the flagged byte or at the fixed block size
   assign block_end = req.last_byte || ({1'b0, pos_ff} + 8'd1 >= LastPos);

   // One byte through the record grammar
   always_comb begin
      phase_nx = phase_ff;
      dif_nx   = dif_ff;
      dife_nx  = dife_ff;
      vif_nx   = vif_ff;
      vife_nx  = vife_ff;
      left_nx  = left_ff;
      bytes_nx = bytes_ff;
      done     = 1'b0;
      len      = dif_payload_len(dif_ff[3:0]);
      idx      = len - left_ff;
      unique case (phase_ff)
         PH_SKIP: begin
            if (pos_ff != 7'd0) phase_nx = PH_DIF;
         end
         PH_DIF: begin
            if (b == FillerByte) begin
               phase_nx = PH_DIF;
            end else if (b[3:0] == DifVarNib || b == DifStopA || b == DifStopB) begin
               phase_nx = PH_HALT;
            end else begin
               dif_nx   = b;
               dife_nx  = 8'd0;
               vif_nx   = 8'd0;
               vife_nx  = 8'd0;
               bytes_nx = 40'd0;
               phase_nx = b[7] ? PH_DIFE : PH_VIF;
            end
         end
         PH_DIFE: begin
            dife_nx = b;
            if (!b[7]) phase_nx = PH_VIF;
         end
         PH_VIF: begin
            vif_nx = b;
            if (b[7]) begin
               phase_nx = PH_VIFE;
            end else if (len == 4'd0) begin
               // last header byte of an empty record
               phase_nx = PH_DIF;
               done     = 1'b1;
            end else begin
               left_nx  = len;
               phase_nx = PH_DATA;
            end
         end
         PH_VIFE: begin
            vife_nx = b;
            if (!b[7]) begin
               // last VIFE byte: enter data, or finish an empty record
               if (len == 4'd0) begin
                  phase_nx = PH_DIF;
                  done     = 1'b1;
               end else begin
                  left_nx  = len;
                  phase_nx = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            case (idx)
               4'd0: bytes_nx[7:0]   = bytes_ff[7:0]   | b;
               4'd1: bytes_nx[15:8]  = bytes_ff[15:8]  | b;
               4'd2: bytes_nx[23:16] = bytes_ff[23:16] | b;
               4'd3: bytes_nx[31:24] = bytes_ff[31:24] | b;
               4'd4: bytes_nx[39:32] = bytes_ff[39:32] | b;
               default: bytes_nx = bytes_ff;
            endcase
            left_nx = left_ff - 4'd1;
            if (left_nx == 4'd0) begin
               phase_nx = PH_DIF;
               done     = 1'b1;
            end
         end
         default: phase_nx = phase_ff;
      endcase
   end

   // Block end returns everything to the reset state
   always_comb begin
      if (block_end) begin
         phase_in = PH_SKIP;
         pos_in   = 7'd0;
         dif_in   = 8'd0;
         dife_in  = 8'd0;
         vif_in   = 8'd0;
         vife_in  = 8'd0;
         left_in  = 4'd0;
         bytes_in = 40'd0;
      end else begin
         phase_in = phase_nx;
         pos_in   = pos_ff + 7'd1;
         dif_in   = dif_nx;
         dife_in  = dife_nx;
         vif_in   = vif_nx;
         vife_in  = vife_nx;
         left_in  = left_nx;
         bytes_in = bytes_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         pos_ff   <= 7'd0;
         dif_ff   <= 8'd0;
         dife_ff  <= 8'd0;
         vif_ff   <= 8'd0;
         vife_ff  <= 8'd0;
         left_ff  <= 4'd0;
         bytes_ff <= 40'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         dif_ff   <= dif_in;
         dife_ff  <= dife_in;
         vif_ff   <= vif_in;
         vife_ff  <= vife_in;
         left_ff  <= left_in;
         bytes_ff <= bytes_in;
      end
   end

   // Record as it stands after this byte
   always_comb begin
      record.done      = done;
      record.dif       = dif_nx;
      record.dif_ext   = dife_nx;
      record.vif       = vif_nx;
      record.vif_ext   = vife_nx;
      record.rec_bytes = bytes_nx;
   end

endmodule
`default_nettype wire

@@ src/mrp_decode.sv @@
`default_nettype none
module mrp_decode
   import mrp_pkg::*;
(
   input  wire record_type record,
   output logic            match,
   output rsp_type         result
);

   logic [7:0] d, de, v, ve, b0, b1, b2, b3, b4;
   logic [3:0] q;
   logic       hit;

   assign d  = record.dif;
   assign de = record.dif_ext;
   assign v  = record.vif;
   assign ve = record.vif_ext;
   assign b0 = record.rec_bytes[7:0];
   assign b1 = record.rec_bytes[15:8];
   assign b2 = record.rec_bytes[23:16];
   assign b3 = record.rec_bytes[31:24];
   assign b4 = record.rec_bytes[39:32];

   // Known quantity codes, first match wins
   always_comb begin
      hit = 1'b1;
      q   = QtyTime;
      if (d == DifInt32 && v == VifEnergy) q = QtyEnergyAp;
      else if (d == DifInt32 && v == VifEnergyEx && ve == VifeNeg) q = QtyEnergyAm;
      else if (d == DifLong && de == DifeTariff && v == VifExtFb && ve == VifeReact)
         q = QtyEnergyRp;
      else if (d == DifLong && de == DifeTariff && v == VifExtFb && ve == VifeNeg)
         q = QtyEnergyRm;
      else if (d == DifInt32 && v == VifPower) q = QtyPowerP;
      else if (d == DifInt32 && v == VifPowerExt && ve == VifeNeg) q = QtyPowerPm;
      else if (d == DifInt32 && de == 8'd0 && v == VifExtFb && ve == VifeReactP)
         q = QtyPowerQ;
      else if (d == DifInt32 && de == 8'd0 && v == VifExtFb && ve == VifeNeg)
         q = QtyPowerQm;
      else if (d == DifInt32 && v == VifEnergyEx && ve == VifePrepay) q = QtyPrepay;
      else hit = 1'b0;
   end

   // Time record takes precedence; invalid flag in second byte drops it
   always_comb begin
      result = '0;
      match  = 1'b0;
      if (v == VifTime && dif_payload_len(d[3:0]) >= 4'd5) begin
         match            = record.done && !b1[7];
         result.quantity  = QtyTime;
         result.ts_second = b0[5:0];
         result.ts_minute = b1[5:0];
         result.ts_hour   = b2[4:0];
         result.ts_day    = b3[4:0];
         result.ts_month  = b4[3:0];
         result.ts_year   = YearBase + {5'd0, b4[7:4], b3[7:5]};
         result.ts_dst    = b0[6];
      end else begin
         match           = record.done && hit;
         result.quantity = q;
         // bytes past the data length are still zero
         result.value    = record.rec_bytes[31:0];
      end
   end

endmodule
`default_nettype wire

@@ src/mrp_out_reg.sv @@
`default_nettype none
module mrp_out_reg
   import mrp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire rsp_type    load_data,
   input  wire logic       rsp_ready,
   output logic            rsp_valid,
   output rsp_type         rsp_data
);

   logic    valid_ff;
   rsp_type data_ff;

   // Holds one result until its transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= load_data;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

@@ src/mbus_record_parser.sv @@
`default_nettype none
// M-Bus DIF/VIF record parser: takes one byte of a decrypted user-data block
// per cycle and yields at most one result per byte, registered, in the cycle
// after the last byte of a matching record. A byte is taken in every cycle in
// which the result register is empty or its result is being transferred, so
// the sustained rate is one byte per clock while rsp_ready is held high; it is
// set by the single output register between the parser state and the result
// channel. After the byte flagged last (or the fixed block size) the parser is
// back in its reset state and the next byte starts a new block.
module mbus_record_parser
   import mrp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data
);

   record_type record;
   rsp_type    result;
   logic       match, accept;

   assign req_ready = !rsp_valid || rsp_ready;
   assign accept    = req_valid && req_ready;

   mrp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .record (record)
   );

   mrp_decode u_decode (
      .record (record),
      .match  (match),
      .result (result)
   );

   mrp_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && match),
      .load_data (result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
